FILE: rtl/core/cfe_pkg.sv
package cfe_pkg;

  localparam int unsigned MaxLen     = 254;
  localparam int unsigned StoreDepth = 254;
  localparam int unsigned AddrW      = $clog2(StoreDepth);
  localparam int unsigned PackBytes  = 8;
  localparam int unsigned CountW     = $clog2(PackBytes + 1);

  localparam logic [7:0] BlockStart = 8'h01;
  localparam logic [7:0] Delimiter  = 8'h00;

  typedef enum logic [1:0] {
    SRC_CODE,
    SRC_RAM,
    SRC_ONE,
    SRC_DELIM
  } byte_src_e;

  typedef struct packed {
    logic      take;
    logic      emit;
    byte_src_e src;
    logic      rd_first;
    logic      rd_next;
    logic      close;
  } ctrl_cmd_t;

  typedef struct packed {
    logic start_flush;
    logic go_done;
    logic last;
    logic zero_flush;
    logic len_zero;
    logic at_end;
    logic emit_ok;
    logic push_ok;
    logic pend;
  } dp_stat_t;

endpackage

FILE: rtl/core/cfe_ram.sv
module cfe_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 254
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/cfe_ctrl.sv
module cfe_ctrl import cfe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CODE  = 3'd1;
  localparam logic [2:0] S_DATA  = 3'd2;
  localparam logic [2:0] S_ONE   = 3'd3;
  localparam logic [2:0] S_DELIM = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_q, state_d;
  logic [2:0] after_run;

  always_comb begin
    if (stat_i.zero_flush && stat_i.last) begin
      after_run = S_ONE;
    end else if (stat_i.last) begin
      after_run = S_DELIM;
    end else begin
      after_run = S_DONE;
    end
  end

  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    cmd_o.src = SRC_CODE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (stat_i.start_flush) begin
            state_d = S_CODE;
          end else if (stat_i.go_done) begin
            state_d = S_DONE;
          end
        end
      end
      S_CODE: begin
        cmd_o.src = SRC_CODE;
        if (stat_i.emit_ok) begin
          cmd_o.emit = 1'b1;
          if (stat_i.len_zero) begin
            state_d = after_run;
          end else begin
            cmd_o.rd_first = 1'b1;
            state_d = S_DATA;
          end
        end
      end
      S_DATA: begin
        cmd_o.src = SRC_RAM;
        if (stat_i.emit_ok) begin
          cmd_o.emit = 1'b1;
          if (stat_i.at_end) begin
            state_d = after_run;
          end else begin
            cmd_o.rd_next = 1'b1;
          end
        end
      end
      S_ONE: begin
        cmd_o.src = SRC_ONE;
        if (stat_i.emit_ok) begin
          cmd_o.emit = 1'b1;
          state_d = S_DELIM;
        end
      end
      S_DELIM: begin
        cmd_o.src = SRC_DELIM;
        if (stat_i.emit_ok) begin
          cmd_o.emit = 1'b1;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!stat_i.pend) begin
          state_d = S_IDLE;
        end else if (stat_i.push_ok) begin
          cmd_o.close = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

FILE: rtl/core/cfe_datapath.sv
module cfe_datapath import cfe_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            data_byte_i,
  input  logic                  last_byte_i,
  input  ctrl_cmd_t             cmd_i,
  output dp_stat_t              stat_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [8*PackBytes-1:0] out_bytes_o,
  output logic [CountW-1:0]     byte_count_o,
  output logic                  end_of_message_o,
  output logic                  overflow_o
);

  logic [7:0]             msg_len_q, msg_len_d;
  logic [AddrW-1:0]       run_len_q, run_len_d;
  logic [AddrW-1:0]       flush_len_q, flush_len_d;
  logic [AddrW-1:0]       idx_q, idx_d;
  logic                   last_q, zero_q, over_q;
  logic [8*PackBytes-1:0] pack_q, pack_d;
  logic [CountW-1:0]      cnt_q, cnt_d;
  logic                   out_valid_q, out_valid_d;
  logic [8*PackBytes-1:0] out_bytes_q, out_bytes_d;
  logic [CountW-1:0]      out_count_q, out_count_d;
  logic                   out_eom_q, out_eom_d;
  logic                   out_ovf_q, out_ovf_d;

  logic             over_now, zero_now, store_now;
  logic             pack_full, can_push;
  logic [7:0]       emit_byte;
  logic             ram_re;
  logic [AddrW-1:0] ram_raddr;
  logic [7:0]       ram_rdata;

  assign over_now  = (msg_len_q >= 8'(MaxLen));
  assign zero_now  = !over_now && (data_byte_i == 8'h00);
  assign store_now = !over_now && (data_byte_i != 8'h00);
  assign pack_full = (cnt_q == CountW'(PackBytes));
  assign can_push  = !out_valid_q || out_ready_i;

  always_comb begin
    case (cmd_i.src)
      SRC_CODE:  emit_byte = 8'(flush_len_q) + BlockStart;
      SRC_RAM:   emit_byte = ram_rdata;
      SRC_ONE:   emit_byte = BlockStart;
      SRC_DELIM: emit_byte = Delimiter;
      default:   emit_byte = Delimiter;
    endcase
  end

  assign ram_re    = cmd_i.rd_first || cmd_i.rd_next;
  assign ram_raddr = cmd_i.rd_first ? '0 : AddrW'(idx_q + AddrW'(1));

  cfe_ram #(
    .Width (8),
    .Depth (StoreDepth)
  ) u_run_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.take && store_now),
    .waddr_i (run_len_q),
    .wdata_i (data_byte_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    msg_len_d   = msg_len_q;
    run_len_d   = run_len_q;
    flush_len_d = flush_len_q;
    idx_d       = idx_q;
    pack_d      = pack_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_bytes_d = out_bytes_q;
    out_count_d = out_count_q;
    out_eom_d   = out_eom_q;
    out_ovf_d   = out_ovf_q;

    if (cmd_i.take) begin
      flush_len_d = run_len_q + AddrW'(store_now);
      if (zero_now || last_byte_i) begin
        run_len_d = '0;
      end else begin
        run_len_d = run_len_q + AddrW'(store_now);
      end
      if (last_byte_i) begin
        msg_len_d = '0;
      end else if (!over_now) begin
        msg_len_d = msg_len_q + 8'd1;
      end
      pack_d = '0;
      cnt_d  = '0;
    end

    if (cmd_i.rd_first) begin
      idx_d = '0;
    end else if (cmd_i.rd_next) begin
      idx_d = idx_q + AddrW'(1);
    end

    if (cmd_i.emit) begin
      if (pack_full) begin
        out_valid_d = 1'b1;
        out_bytes_d = pack_q;
        out_count_d = cnt_q;
        out_eom_d   = 1'b0;
        out_ovf_d   = over_q;
        pack_d      = {{(8*PackBytes-8){1'b0}}, emit_byte};
        cnt_d       = CountW'(1);
      end else begin
        pack_d[{cnt_q[CountW-2:0], 3'b000} +: 8] = emit_byte;
        cnt_d = cnt_q + CountW'(1);
      end
    end

    if (cmd_i.close) begin
      out_valid_d = 1'b1;
      out_bytes_d = pack_q;
      out_count_d = cnt_q;
      out_eom_d   = last_q;
      out_ovf_d   = over_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_len_q   <= '0;
      run_len_q   <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      msg_len_q   <= msg_len_d;
      run_len_q   <= run_len_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    flush_len_q <= flush_len_d;
    idx_q       <= idx_d;
    pack_q      <= pack_d;
    out_bytes_q <= out_bytes_d;
    out_count_q <= out_count_d;
    out_eom_q   <= out_eom_d;
    out_ovf_q   <= out_ovf_d;
    if (cmd_i.take) begin
      last_q <= last_byte_i;
      zero_q <= zero_now;
      over_q <= over_now;
    end
  end

  always_comb begin
    stat_o             = '0;
    stat_o.start_flush = zero_now || last_byte_i;
    stat_o.go_done     = over_now;
    stat_o.last        = last_q;
    stat_o.zero_flush  = zero_q;
    stat_o.len_zero    = (flush_len_q == '0);
    stat_o.at_end      = (idx_q == AddrW'(flush_len_q - AddrW'(1)));
    stat_o.emit_ok     = !pack_full || can_push;
    stat_o.push_ok     = can_push;
    stat_o.pend        = (cnt_q != '0) || over_q;
  end

  assign out_valid_o      = out_valid_q;
  assign out_bytes_o      = out_bytes_q;
  assign byte_count_o     = out_count_q;
  assign end_of_message_o = out_eom_q;
  assign overflow_o       = out_ovf_q;

endmodule

FILE: rtl/core/cobs_frame_encoder_core.sv
// COBS encoder for a byte stream. The input channel takes one message byte per
// transfer on data_byte_i, with last_byte_i set on the final byte of a message.
// The output channel delivers encoded bytes packed up to eight per transfer,
// first byte in bits 7:0, with byte_count_o giving how many are valid.
// A non-zero byte that does not end the message is stored and gives no output;
// such bytes are taken one per cycle. A zero byte or the end of a message
// flushes the run: the block stops taking input while it emits the code byte,
// the stored bytes and, at message end, the closing zero, one byte per cycle
// while the output does not stall, as the stored bytes are read back from
// the run memory, and then hands over the last partial word. A final zero
// byte also closes an empty block. The final transfer of a message carries
// end_of_message_o. Bytes beyond 254 in one message are dropped and reported
// with overflow_o. Reset empties the run and the message count; the run memory
// needs no clearing. When the receiver stalls, one finished transfer waits in
// the output register while encoding goes on into the packing register; the
// flush holds when both are full, or when the last partial word is ready
// while the output register is occupied.
module cobs_frame_encoder_core import cfe_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             data_byte_i,
  input  logic                   last_byte_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [8*PackBytes-1:0] out_bytes_o,
  output logic [CountW-1:0]      byte_count_o,
  output logic                   end_of_message_o,
  output logic                   overflow_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  cfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cfe_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .data_byte_i      (data_byte_i),
    .last_byte_i      (last_byte_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_bytes_o      (out_bytes_o),
    .byte_count_o     (byte_count_o),
    .end_of_message_o (end_of_message_o),
    .overflow_o       (overflow_o)
  );

endmodule

FILE: dv/tb_top.sv
module tb_top import cfe_pkg::*; ();

  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned DrainCycles = 300;
  localparam int unsigned MaxPrinted  = 40;

  typedef struct {
    logic [8*PackBytes-1:0] bytes;
    logic [CountW-1:0]      count;
    logic                   eom;
    logic                   ovf;
  } enc_word_t;

  logic                   clk_i;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [7:0]             data_byte_i = 8'h00;
  logic                   last_byte_i = 1'b0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [8*PackBytes-1:0] out_bytes_o;
  logic [CountW-1:0]      byte_count_o;
  logic                   end_of_message_o;
  logic                   overflow_o;

  logic [7:0] run_bytes [MaxLen];
  int unsigned run_len = 0;
  int unsigned msg_len = 0;
  logic [7:0] stream_bytes [$];
  enc_word_t  expected_words [$];

  bit idle_en = 1'b1;
  int unsigned error_count = 0;
  int unsigned items_sent = 0;
  int unsigned messages_done = 0;
  int unsigned words_checked = 0;
  int unsigned overflow_words = 0;
  int unsigned quiet_cycles = 0;

  cobs_frame_encoder_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .last_byte_i     (last_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_bytes_o     (out_bytes_o),
    .byte_count_o    (byte_count_o),
    .end_of_message_o(end_of_message_o),
    .overflow_o      (overflow_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void flush_run_bytes();
    stream_bytes.push_back(8'(run_len) + BlockStart);
    for (int unsigned i = 0; i < run_len; i++) begin
      stream_bytes.push_back(run_bytes[i]);
    end
    run_len = 0;
  endfunction

  function automatic void encode_byte(input logic [7:0] data, input logic last);
    logic       dropped;
    enc_word_t  w;
    int unsigned n;
    dropped = 1'b0;
    stream_bytes.delete();
    if (msg_len >= MaxLen) begin
      dropped = 1'b1;
    end else begin
      msg_len++;
      if (data == 8'h00) begin
        flush_run_bytes();
      end else begin
        run_bytes[run_len] = data;
        run_len++;
      end
    end
    if (last) begin
      flush_run_bytes();
      stream_bytes.push_back(Delimiter);
      msg_len = 0;
      messages_done++;
    end
    if (stream_bytes.size() == 0) begin
      if (dropped) begin
        w.bytes = '0;
        w.count = '0;
        w.eom   = 1'b0;
        w.ovf   = 1'b1;
        expected_words.push_back(w);
      end
      return;
    end
    for (int unsigned pos = 0; pos < stream_bytes.size(); pos += PackBytes) begin
      n = stream_bytes.size() - pos;
      if (n > PackBytes) n = PackBytes;
      w.bytes = '0;
      for (int unsigned k = 0; k < n; k++) begin
        w.bytes[8*k +: 8] = stream_bytes[pos + k];
      end
      w.count = CountW'(n);
      w.eom   = last && (pos + n == stream_bytes.size());
      w.ovf   = dropped;
      expected_words.push_back(w);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] exp_v,
                                 input logic [63:0] got_v);
    error_count++;
    if (error_count <= MaxPrinted) begin
      $display("MISMATCH %s on output transfer %0d: expected %h, got %h",
               what, words_checked, exp_v, got_v);
    end
  endtask

  task automatic check_word();
    enc_word_t w;
    if (expected_words.size() == 0) begin
      report_mismatch("unexpected transfer", '0, out_bytes_o);
    end else begin
      w = expected_words.pop_front();
      if (out_bytes_o !== w.bytes) report_mismatch("out_bytes", w.bytes, out_bytes_o);
      if (byte_count_o !== w.count) begin
        report_mismatch("byte_count", 64'(w.count), 64'(byte_count_o));
      end
      if (end_of_message_o !== w.eom) begin
        report_mismatch("end_of_message", 64'(w.eom), 64'(end_of_message_o));
      end
      if (overflow_o !== w.ovf) begin
        report_mismatch("overflow", 64'(w.ovf), 64'(overflow_o));
      end
      if (w.ovf) overflow_words++;
    end
    words_checked++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) encode_byte(data_byte_i, last_byte_i);
    if (rst_ni && out_valid_o && out_ready_i) check_word();
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("Timeout: no transfer for %0d cycles.", QuietLimit);
        $display("cobs_frame_encoder_core regression: fail");
        $finish;
      end
    end
  end

  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (idle_en && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
  end

  task automatic send_byte(input logic [7:0] data, input logic last);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= data;
    last_byte_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic send_random_message(input int unsigned len, input int unsigned zero_pct);
    logic [7:0] data;
    for (int unsigned i = 0; i < len; i++) begin
      data = ($urandom_range(0, 99) < zero_pct) ? 8'h00 : 8'($urandom_range(1, 255));
      send_byte(data, i == len - 1);
    end
  endtask

  // Short messages around the field extremes, zero runs and word boundaries.
  task automatic test_directed();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    for (int unsigned i = 0; i < 10; i++) begin
      send_byte(8'(8'h11 * (i + 1)), i == 9);
    end
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // A message filled to the limit with non-zero bytes gives one block with code 0xFF,
  // and the bytes past the limit are dropped, including a dropped final byte.
  task automatic test_overflow();
    for (int unsigned i = 0; i < MaxLen; i++) begin
      send_byte(8'(255 - i % 255), 1'b0);
    end
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h3C, 1'b1);
  endtask

  task automatic test_random(input int unsigned item_budget);
    int unsigned target;
    int unsigned len;
    target = items_sent + item_budget;
    while (items_sent < target) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      send_random_message(len, $urandom_range(0, 50));
    end
  endtask

  task automatic wait_for_drain();
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_overflow();
    test_random(45);
    idle_en = 1'b0;
    test_random(25);
    in_valid_i <= 1'b0;
    wait_for_drain();
    for (int unsigned i = 0; i < expected_words.size(); i++) begin
      report_mismatch("missing transfer", expected_words[i].bytes, '0);
    end
    $display("Encoded %0d messages from %0d input bytes, including full-run and overflow",
             messages_done, items_sent);
    $display("cases; checked %0d output transfers, %0d of them flagged overflow.",
             words_checked, overflow_words);
    if (error_count == 0) begin
      $display("cobs_frame_encoder_core regression: pass");
    end else begin
      $display("cobs_frame_encoder_core regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/cfe_pkg.sv
rtl/core/cfe_ram.sv
rtl/core/cfe_ctrl.sv
rtl/core/cfe_datapath.sv
rtl/core/cobs_frame_encoder_core.sv
dv/tb_top.sv
